// ===== sv/ndpf_pkg.sv =====
// ----------------------------------------------------------------------------
// ndpf_pkg
// Shared types, constants and arithmetic helpers for the near-duplicate
// point filter.
// ----------------------------------------------------------------------------
package ndpf_pkg;

  localparam int COORD_W = 32;
  localparam int TOL_W   = 31;
  localparam int DUP_W   = 16;
  localparam int SQ_W    = 64;

  localparam logic [TOL_W-1:0] TOL_RESET = TOL_W'(328);
  localparam logic [DUP_W-1:0] DUP_MAX   = {DUP_W{1'b1}};

  typedef logic signed [COORD_W-1:0] coord_t;

  // One input vertex as it waits in the front queue.
  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
    logic   last;
  } item_t;

  // One entry of the unique-vertex store.
  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
  } entry_t;

  // One result transaction.
  typedef struct packed {
    coord_t             x;
    coord_t             y;
    coord_t             z;
    logic               kept;
    logic [DUP_W-1:0]   dup_count;
    logic               table_full;
    logic               last;
  } result_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_DONE
  } state_t;

  // Magnitude of the exact 33-bit difference of two signed coordinates.
  function automatic logic [COORD_W:0] abs_diff(input coord_t a, input coord_t b);
    logic [COORD_W:0] d;
    d = {a[COORD_W-1], a} - {b[COORD_W-1], b};
    return d[COORD_W] ? (~d + (COORD_W+1)'(1)) : d;
  endfunction

  // Unsigned add that saturates at all ones.
  function automatic logic [SQ_W-1:0] sat_add(input logic [SQ_W-1:0] a,
                                              input logic [SQ_W-1:0] b);
    logic [SQ_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[SQ_W] ? {SQ_W{1'b1}} : s[SQ_W-1:0];
  endfunction

endpackage

// ===== sv/near_duplicate_point_filter.sv =====
// ----------------------------------------------------------------------------
// near_duplicate_point_filter
// Flags vertices of a contour that lie closer than the tolerance to an
// earlier unique vertex of the same contour.
// ----------------------------------------------------------------------------
// Usage:
// Vertices enter as queue transactions: drive in_coord_* and in_last_in and
// raise in_push; a transaction is taken on a clock edge where in_full is low.
// Results leave the same way: while out_empty is low the oldest result sits
// on the out_ ports and is taken on an edge where out_pop is high.
// Each vertex gives exactly one result, in order. A vertex is compared with
// every unique vertex stored so far, one per cycle through the distance
// pipeline; the search stops early on a match. The engine works on one item
// at a time and takes no new one before the result of the last has gone into
// the result queue. A two-entry queue on each side keeps accepting while a
// finished result waits; when the receiver stalls the queues fill and in_full
// rises. A vertex with in_last_in set empties the store and the duplicate
// count after its result.
// Reset (rst_n low, synchronous) empties both queues and the store and
// loads the tolerance with 328 (about 0.005 in Q16.16). cfg_we writes the
// tolerance from cfg_wdata; write it only while the block is idle.
// ----------------------------------------------------------------------------
module near_duplicate_point_filter
  import ndpf_pkg::*;
#(
  parameter int MAX_VERTICES = 256
)
(
  input  logic                clk,
  input  logic                rst_n,
  // Input channel
  input  logic                in_push,
  output logic                in_full,
  input  logic signed [31:0]  in_coord_x,
  input  logic signed [31:0]  in_coord_y,
  input  logic signed [31:0]  in_coord_z,
  input  logic                in_last_in,
  // Result channel
  output logic                out_empty,
  input  logic                out_pop,
  output logic signed [31:0]  out_x,
  output logic signed [31:0]  out_y,
  output logic signed [31:0]  out_z,
  output logic                out_kept,
  output logic [15:0]         out_dup_count,
  output logic                out_table_full,
  output logic                out_last_out,
  // Configuration
  input  logic                cfg_we,
  input  logic [30:0]         cfg_wdata
);

  item_t   push_item;
  item_t   head_item;
  logic    fq_empty;
  logic    item_pop;
  result_t eng_res;
  result_t head_res;
  logic    res_push;
  logic    oq_full;

  assign push_item = '{x: in_coord_x, y: in_coord_y, z: in_coord_z, last: in_last_in};

  // Front queue.
  ndpf_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_push),
    .full      (in_full),
    .push_item (push_item),
    .pop       (item_pop),
    .empty     (fq_empty),
    .head_item (head_item)
  );

  // Search engine and vertex store.
  ndpf_engine #(
    .MAX_VERTICES (MAX_VERTICES)
  ) u_engine (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .item_valid (!fq_empty),
    .item       (head_item),
    .item_pop   (item_pop),
    .res_full   (oq_full),
    .res_push   (res_push),
    .res        (eng_res)
  );

  // Result queue.
  ndpf_outq u_outq (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (res_push),
    .full     (oq_full),
    .push_res (eng_res),
    .pop      (out_pop),
    .empty    (out_empty),
    .head_res (head_res)
  );

  assign out_x          = head_res.x;
  assign out_y          = head_res.y;
  assign out_z          = head_res.z;
  assign out_kept       = head_res.kept;
  assign out_dup_count  = head_res.dup_count;
  assign out_table_full = head_res.table_full;
  assign out_last_out   = head_res.last;

`ifndef SYNTHESIS
  // The engine only hands a result to a queue that has room.
  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    res_push |-> !oq_full)
    else $error("result pushed into a full queue");

  // The engine only retires an item that is present, together with its result.
  a_pop_match: assert property (@(posedge clk) disable iff (!rst_n)
    item_pop |-> (!fq_empty && res_push))
    else $error("item retired without a result or from an empty queue");

  // A full store is reported only for a kept vertex.
  a_full_kept: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_table_full) |-> out_kept)
    else $error("table_full on a duplicate");

  // A duplicate always has a nonzero duplicate count.
  a_dup_count: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_kept) |-> (out_dup_count != 16'd0))
    else $error("duplicate with zero count");
`endif

endmodule

// ===== sv/ndpf_front.sv =====
// ----------------------------------------------------------------------------
// ndpf_front
// Two-entry input queue that accepts vertices and holds them for the
// search engine.
// ----------------------------------------------------------------------------
module ndpf_front
  import ndpf_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  output logic  full,
  input  item_t push_item,
  input  logic  pop,
  output logic  empty,
  output item_t head_item
);

  item_t      q_r [2];
  logic       wp_r;
  logic       rp_r;
  logic [1:0] cnt_r;
  logic       do_push;
  logic       do_pop;

  assign full      = (cnt_r == 2'd2);
  assign empty     = (cnt_r == 2'd0);
  assign do_push   = push && !full;
  assign do_pop    = pop && !empty;
  assign head_item = q_r[rp_r];

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (do_push) begin
        wp_r <= ~wp_r;
      end
      if (do_pop) begin
        rp_r <= ~rp_r;
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 2'd1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 2'd1;
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      q_r[wp_r] <= push_item;
    end
  end

endmodule

// ===== sv/ndpf_outq.sv =====
// ----------------------------------------------------------------------------
// ndpf_outq
// Two-entry result queue between the search engine and the receiver.
// ----------------------------------------------------------------------------
module ndpf_outq
  import ndpf_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  output logic    full,
  input  result_t push_res,
  input  logic    pop,
  output logic    empty,
  output result_t head_res
);

  result_t    q_r [2];
  logic       wp_r;
  logic       rp_r;
  logic [1:0] cnt_r;
  logic       do_push;
  logic       do_pop;

  assign full     = (cnt_r == 2'd2);
  assign empty    = (cnt_r == 2'd0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign head_res = q_r[rp_r];

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (do_push) begin
        wp_r <= ~wp_r;
      end
      if (do_pop) begin
        rp_r <= ~rp_r;
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 2'd1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 2'd1;
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      q_r[wp_r] <= push_res;
    end
  end

endmodule

// ===== sv/ndpf_engine.sv =====
// ----------------------------------------------------------------------------
// ndpf_engine
// Search engine: compares the head vertex against the stored unique vertices
// through a distance pipeline until a match, then updates the store and counters
// and hands one result to the output queue.
// ----------------------------------------------------------------------------
module ndpf_engine
  import ndpf_pkg::*;
#(
  parameter int MAX_VERTICES = 256
)
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic [TOL_W-1:0] cfg_wdata,
  input  logic             item_valid,
  input  item_t            item,
  output logic             item_pop,
  input  logic             res_full,
  output logic             res_push,
  output result_t          res
);

  localparam int AW = $clog2(MAX_VERTICES);
  localparam int CW = $clog2(MAX_VERTICES + 1);

  // Unique-vertex store.
  entry_t mem [MAX_VERTICES];

  state_t            state_r, state_nxt;
  logic [CW-1:0]     idx_r, idx_nxt;
  logic              hit_r, hit_nxt;
  logic [CW-1:0]     count_r;
  logic [DUP_W-1:0]  dup_r;
  logic [DUP_W-1:0]  dup_inc;
  logic [TOL_W-1:0]  tol_r;
  logic [SQ_W-1:0]   tol2_r;

  // Distance pipeline.
  logic              v1_r, v2_r, v3_r, v4_r;
  entry_t            rd_data_r;
  logic [COORD_W:0]  magx_r, magy_r, magz_r;
  logic [SQ_W-1:0]   sqx_r, sqy_r, sqz_r;
  logic [SQ_W-1:0]   sxy_r, sqz_d_r;
  logic [SQ_W-1:0]   dist2;
  logic              issue;
  logic              pipe_busy;
  logic              store_full;
  logic              mem_we;

  assign issue      = (state_r == ST_SEARCH) && !hit_r && (idx_r != count_r);
  assign pipe_busy  = v1_r || v2_r || v3_r || v4_r;
  assign store_full = (count_r == CW'(MAX_VERTICES));
  assign dist2      = sat_add(sxy_r, sqz_d_r);
  assign dup_inc    = (hit_r && (dup_r != DUP_MAX)) ? dup_r + DUP_W'(1) : dup_r;

  // Result assembled from the head vertex and the search outcome.
  always_comb begin
    res.x          = item.x;
    res.y          = item.y;
    res.z          = item.z;
    res.kept       = !hit_r;
    res.dup_count  = dup_inc;
    res.table_full = !hit_r && store_full;
    res.last       = item.last;
  end

  // Sequencer next state and strobes.
  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    hit_nxt   = hit_r;
    item_pop  = 1'b0;
    res_push  = 1'b0;
    mem_we    = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (item_valid) begin
          idx_nxt   = '0;
          hit_nxt   = 1'b0;
          state_nxt = ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        if (issue) begin
          idx_nxt = idx_r + CW'(1);
        end
        if (v4_r && (dist2 < tol2_r)) begin
          hit_nxt = 1'b1;
        end
        if (!issue && !pipe_busy) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!res_full) begin
          res_push  = 1'b1;
          item_pop  = 1'b1;
          mem_we    = !hit_r && !store_full;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      idx_r   <= '0;
      hit_r   <= 1'b0;
      count_r <= '0;
      dup_r   <= '0;
      tol_r   <= TOL_RESET;
      v1_r    <= 1'b0;
      v2_r    <= 1'b0;
      v3_r    <= 1'b0;
      v4_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
      hit_r   <= hit_nxt;
      v1_r    <= issue;
      v2_r    <= v1_r;
      v3_r    <= v2_r;
      v4_r    <= v3_r;
      if (cfg_we) begin
        tol_r <= cfg_wdata;
      end
      // The last vertex of a contour empties the store after its result.
      if (res_push) begin
        if (item.last) begin
          count_r <= '0;
          dup_r   <= '0;
        end else begin
          if (mem_we) begin
            count_r <= count_r + CW'(1);
          end
          dup_r <= dup_inc;
        end
      end
    end
  end

  // Store write and registered read.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[count_r[AW-1:0]] <= '{x: item.x, y: item.y, z: item.z};
    end
    if (issue) begin
      rd_data_r <= mem[idx_r[AW-1:0]];
    end
  end

  // Squared tolerance, in the same raw units as the distance.
  always_ff @(posedge clk) begin
    tol2_r <= SQ_W'(tol_r) * SQ_W'(tol_r);
  end

  // Distance datapath: magnitudes, squares, then two saturating adds.
  always_ff @(posedge clk) begin
    magx_r  <= abs_diff(item.x, rd_data_r.x);
    magy_r  <= abs_diff(item.y, rd_data_r.y);
    magz_r  <= abs_diff(item.z, rd_data_r.z);
    sqx_r   <= magx_r[COORD_W] ? {SQ_W{1'b1}} :
               SQ_W'(magx_r[COORD_W-1:0]) * SQ_W'(magx_r[COORD_W-1:0]);
    sqy_r   <= magy_r[COORD_W] ? {SQ_W{1'b1}} :
               SQ_W'(magy_r[COORD_W-1:0]) * SQ_W'(magy_r[COORD_W-1:0]);
    sqz_r   <= magz_r[COORD_W] ? {SQ_W{1'b1}} :
               SQ_W'(magz_r[COORD_W-1:0]) * SQ_W'(magz_r[COORD_W-1:0]);
    sxy_r   <= sat_add(sqx_r, sqy_r);
    sqz_d_r <= sqz_r;
  end

endmodule
